### src/itc_pkg.sv
// Shared types and constants for the interval timer channel.
`timescale 1ns / 1ps

package itc_pkg;

    // Request kinds carried in the input tuser field
    typedef enum logic [2:0] {
        REQ_CTRL  = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_READ  = 3'd2,
        REQ_GATE  = 3'd3,
        REQ_CLOCK = 3'd4
    } req_t;

    // Byte access codes of the control word
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_BOTH  = 2'd3;

    // Select code that leaves the control word without effect
    localparam logic [1:0] SEL_NONE = 2'd3;

    // Counter modes after folding modes 6 and 7
    localparam logic [2:0] MODE_INT_TERM   = 3'd0;
    localparam logic [2:0] MODE_ONE_SHOT   = 3'd1;
    localparam logic [2:0] MODE_RATE_GEN   = 3'd2;
    localparam logic [2:0] MODE_SQUARE     = 3'd3;
    localparam logic [2:0] MODE_SW_STROBE  = 3'd4;
    localparam logic [2:0] MODE_HW_STROBE  = 3'd5;

    localparam logic [15:0] MASK_HIGH = 16'hff00;
    localparam logic [15:0] MASK_LOW  = 16'h00ff;
    localparam logic [15:0] MASK_EVEN = 16'hfffe;

endpackage

### src/interval_timer_counter_channel_unit.sv
// Top level of one 16-bit channel of an 8254-style interval timer.
`timescale 1ns / 1ps

// One counter channel of an 8254-style programmable interval timer, driven by a
// stream of request beats: control word writes, count byte writes, byte reads,
// and new GATE or CLK pin levels. Every request beat yields exactly one result
// beat carrying the read byte (zero for anything but a read) and the OUT pin
// level after the request. The channel state and the result register update on
// the accepting edge, and a new request is taken in every cycle while the result
// register is empty or being drained. Counting runs on CLK falling edges, GATE
// is sampled on CLK rising edges, modes 6 and 7 act as 2 and 3, counting is
// binary only and status read-back is not provided.
module interval_timer_counter_channel_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data, [8] level, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] out_pin, [15:9] zero
);

    // Channel state
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  access_reg, access_next;
    logic [15:0] reload_reg, reload_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] latched_reg, latched_next;
    logic        latch_held_reg, latch_held_next;
    logic        rd_phase_reg, rd_phase_next;
    logic        wr_phase_reg, wr_phase_next;
    logic        load_pend_reg, load_pend_next;
    logic        awaiting_reg, awaiting_next;
    logic        gate_lvl_reg, gate_lvl_next;
    logic        gate_trig_reg, gate_trig_next;
    logic        gate_smp_reg, gate_smp_next;
    logic        out_reg, out_next;
    logic        clk_lvl_reg, clk_lvl_next;
    logic        odd_reg, odd_next;
    logic        done_reg, done_next;

    // Result register
    logic        valid_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        pin_reg;

    logic        accept;
    logic [2:0]  eff_mode;
    logic [7:0]  din;
    logic        lvl;
    logic [15:0] src;
    logic [15:0] dec1;
    logic [15:0] dec2;

    // Take a beat whenever the result register is free or drains this cycle
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign din  = s_tdata[7:0];
    assign lvl  = s_tdata[8];
    assign src  = latch_held_reg ? latched_reg : count_reg;
    assign dec1 = count_reg - 16'd1;
    assign dec2 = count_reg - 16'd2;

    // Fold modes 6 and 7 onto 2 and 3
    assign eff_mode = (mode_reg >= 3'd6) ? (mode_reg - 3'd4) : mode_reg;

    always_comb
    begin
        logic [2:0]  new_mode;
        logic [2:0]  new_eff;
        logic        wr_done;
        logic        lp;
        mode_next       = mode_reg;
        access_next     = access_reg;
        reload_next     = reload_reg;
        count_next      = count_reg;
        latched_next    = latched_reg;
        latch_held_next = latch_held_reg;
        rd_phase_next   = rd_phase_reg;
        wr_phase_next   = wr_phase_reg;
        load_pend_next  = load_pend_reg;
        awaiting_next   = awaiting_reg;
        gate_lvl_next   = gate_lvl_reg;
        gate_trig_next  = gate_trig_reg;
        gate_smp_next   = gate_smp_reg;
        out_next        = out_reg;
        clk_lvl_next    = clk_lvl_reg;
        odd_next        = odd_reg;
        done_next       = done_reg;
        rdata_next      = 8'h00;
        new_mode        = din[3:1];
        new_eff         = (new_mode >= 3'd6) ? (new_mode - 3'd4) : new_mode;
        wr_done         = 1'b0;
        lp              = load_pend_reg || gate_smp_reg;

        case (s_tuser)
            itc_pkg::REQ_CTRL:
            begin
                if (din[7:6] != itc_pkg::SEL_NONE) begin
                    if (din[5:4] == itc_pkg::ACC_LATCH) begin
                        // Drop a second latch while the first is unread
                        if (!latch_held_reg) begin
                            latched_next    = count_reg;
                            latch_held_next = 1'b1;
                            rd_phase_next   = 1'b0;
                        end
                    end else begin
                        access_next    = din[5:4];
                        mode_next      = new_mode;
                        rd_phase_next  = 1'b0;
                        wr_phase_next  = 1'b0;
                        awaiting_next  = 1'b1;
                        load_pend_next = 1'b0;
                        if (new_eff == itc_pkg::MODE_INT_TERM) begin
                            out_next = 1'b0;
                        end else begin
                            out_next       = 1'b1;
                            gate_smp_next  = 1'b0;
                            gate_trig_next = 1'b0;
                            if (new_eff == itc_pkg::MODE_SQUARE) begin
                                odd_next = 1'b0;
                            end
                        end
                    end
                end
            end
            itc_pkg::REQ_WRITE:
            begin
                case (access_reg)
                    itc_pkg::ACC_LOW:
                    begin
                        reload_next = {8'h00, din};
                        wr_done     = 1'b1;
                    end
                    itc_pkg::ACC_HIGH:
                    begin
                        reload_next = {din, 8'h00};
                        wr_done     = 1'b1;
                    end
                    itc_pkg::ACC_BOTH:
                    begin
                        if (!wr_phase_reg) begin
                            reload_next   = (reload_reg & itc_pkg::MASK_HIGH) | {8'h00, din};
                            awaiting_next = 1'b1;
                            if (eff_mode == itc_pkg::MODE_INT_TERM) begin
                                out_next = 1'b0;
                            end
                        end else begin
                            reload_next = (reload_reg & itc_pkg::MASK_LOW) | {din, 8'h00};
                            wr_done     = 1'b1;
                        end
                        wr_phase_next = !wr_phase_reg;
                    end
                    default:
                    begin
                    end
                endcase
                if (wr_done) begin
                    // Arm the load of the new count
                    if (eff_mode == itc_pkg::MODE_INT_TERM ||
                        eff_mode == itc_pkg::MODE_SW_STROBE) begin
                        load_pend_next = 1'b1;
                    end else if (eff_mode == itc_pkg::MODE_RATE_GEN ||
                                 eff_mode == itc_pkg::MODE_SQUARE) begin
                        load_pend_next = awaiting_reg;
                    end
                    awaiting_next = 1'b0;
                end
            end
            itc_pkg::REQ_READ:
            begin
                case (access_reg)
                    itc_pkg::ACC_LOW:
                    begin
                        rdata_next      = src[7:0];
                        latch_held_next = 1'b0;
                    end
                    itc_pkg::ACC_HIGH:
                    begin
                        rdata_next      = src[15:8];
                        latch_held_next = 1'b0;
                    end
                    itc_pkg::ACC_BOTH:
                    begin
                        if (!rd_phase_reg) begin
                            rdata_next = src[7:0];
                        end else begin
                            rdata_next      = src[15:8];
                            latch_held_next = 1'b0;
                        end
                        rd_phase_next = !rd_phase_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            itc_pkg::REQ_GATE:
            begin
                if (gate_lvl_reg != lvl) begin
                    gate_lvl_next = lvl;
                    if (lvl) begin
                        if (eff_mode == itc_pkg::MODE_ONE_SHOT ||
                            eff_mode == itc_pkg::MODE_HW_STROBE) begin
                            gate_trig_next = 1'b1;
                        end else if (eff_mode == itc_pkg::MODE_RATE_GEN ||
                                     eff_mode == itc_pkg::MODE_SQUARE) begin
                            gate_smp_next  = 1'b1;
                            gate_trig_next = 1'b1;
                            load_pend_next = 1'b1;
                        end
                    end else if (eff_mode == itc_pkg::MODE_RATE_GEN ||
                                 eff_mode == itc_pkg::MODE_SQUARE) begin
                        out_next = 1'b1;
                    end
                end
            end
            itc_pkg::REQ_CLOCK:
            begin
                if (clk_lvl_reg != lvl) begin
                    clk_lvl_next = lvl;
                    if (!awaiting_reg) begin
                        if (lvl) begin
                            // Rising edge: sample the gate
                            if (eff_mode == itc_pkg::MODE_INT_TERM ||
                                eff_mode == itc_pkg::MODE_SW_STROBE) begin
                                gate_smp_next = gate_lvl_reg;
                            end else if (eff_mode == itc_pkg::MODE_ONE_SHOT ||
                                         eff_mode == itc_pkg::MODE_HW_STROBE) begin
                                gate_smp_next = gate_trig_reg;
                            end else begin
                                gate_smp_next = gate_trig_reg || gate_lvl_reg;
                            end
                            gate_trig_next = 1'b0;
                        end else begin
                            // Falling edge: advance the count
                            case (eff_mode)
                                itc_pkg::MODE_INT_TERM:
                                begin
                                    if (load_pend_reg) begin
                                        count_next     = reload_reg;
                                        load_pend_next = 1'b0;
                                    end else if (gate_smp_reg) begin
                                        count_next = dec1;
                                        if (dec1 == 16'd0) begin
                                            out_next = 1'b1;
                                        end
                                    end
                                end
                                itc_pkg::MODE_ONE_SHOT:
                                begin
                                    if (lp) begin
                                        count_next     = reload_reg;
                                        out_next       = 1'b0;
                                        load_pend_next = 1'b0;
                                    end else begin
                                        count_next = dec1;
                                        if (dec1 == 16'd0) begin
                                            out_next = 1'b1;
                                        end
                                    end
                                end
                                itc_pkg::MODE_RATE_GEN:
                                begin
                                    if (gate_smp_reg && load_pend_reg) begin
                                        count_next     = reload_reg;
                                        out_next       = 1'b1;
                                        load_pend_next = 1'b0;
                                    end else if (!gate_smp_reg) begin
                                        out_next = 1'b1;
                                    end else if (dec1 == 16'd0) begin
                                        count_next = reload_reg;
                                        out_next   = (reload_reg != 16'd1);
                                    end else begin
                                        count_next = dec1;
                                        out_next   = (dec1 != 16'd1);
                                    end
                                end
                                itc_pkg::MODE_SQUARE:
                                begin
                                    if (gate_smp_reg && load_pend_reg) begin
                                        count_next     = reload_reg & itc_pkg::MASK_EVEN;
                                        odd_next       = reload_reg[0];
                                        out_next       = 1'b1;
                                        load_pend_next = 1'b0;
                                    end else if (!gate_smp_reg) begin
                                        out_next = 1'b1;
                                    end else if (odd_reg && out_reg && count_reg == 16'd0) begin
                                        count_next = reload_reg & itc_pkg::MASK_EVEN;
                                        odd_next   = reload_reg[0];
                                        out_next   = !out_reg;
                                    end else if (odd_reg && out_reg) begin
                                        count_next = dec2;
                                    end else if (dec2 == 16'd0) begin
                                        count_next = reload_reg & itc_pkg::MASK_EVEN;
                                        odd_next   = reload_reg[0];
                                        out_next   = !out_reg;
                                    end else begin
                                        count_next = dec2;
                                    end
                                end
                                default:
                                begin
                                    // Strobe modes: software or hardware start
                                    if ((eff_mode == itc_pkg::MODE_SW_STROBE)
                                            ? load_pend_reg : lp) begin
                                        count_next     = reload_reg;
                                        load_pend_next = 1'b0;
                                        done_next      = 1'b0;
                                    end else if (eff_mode != itc_pkg::MODE_SW_STROBE ||
                                                 gate_smp_reg) begin
                                        count_next = dec1;
                                        if (dec1 == 16'd0 && !done_reg) begin
                                            out_next  = 1'b0;
                                            done_next = 1'b1;
                                        end else begin
                                            out_next = 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= 3'd0;
            access_reg     <= 2'd0;
            reload_reg     <= 16'd0;
            count_reg      <= 16'd0;
            latched_reg    <= 16'd0;
            latch_held_reg <= 1'b0;
            rd_phase_reg   <= 1'b0;
            wr_phase_reg   <= 1'b0;
            load_pend_reg  <= 1'b0;
            awaiting_reg   <= 1'b0;
            gate_lvl_reg   <= 1'b0;
            gate_trig_reg  <= 1'b0;
            gate_smp_reg   <= 1'b0;
            out_reg        <= 1'b0;
            clk_lvl_reg    <= 1'b0;
            odd_reg        <= 1'b0;
            done_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg       <= mode_next;
                access_reg     <= access_next;
                reload_reg     <= reload_next;
                count_reg      <= count_next;
                latched_reg    <= latched_next;
                latch_held_reg <= latch_held_next;
                rd_phase_reg   <= rd_phase_next;
                wr_phase_reg   <= wr_phase_next;
                load_pend_reg  <= load_pend_next;
                awaiting_reg   <= awaiting_next;
                gate_lvl_reg   <= gate_lvl_next;
                gate_trig_reg  <= gate_trig_next;
                gate_smp_reg   <= gate_smp_next;
                out_reg        <= out_next;
                clk_lvl_reg    <= clk_lvl_next;
                odd_reg        <= odd_next;
                done_reg       <= done_next;
                valid_reg      <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled, load on every accepted beat
    always_ff @(posedge clk)
    begin
        if (accept) begin
            rdata_reg <= rdata_next;
            pin_reg   <= out_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, pin_reg, rdata_reg};

endmodule

### src/itc_checker.sv
// Port-level assertions for the interval timer channel, with their bind.
`timescale 1ns / 1ps

module itc_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic acc;
    logic mode_set;
    assign acc      = s_tvalid && s_tready;
    assign mode_set = acc && (s_tuser == itc_pkg::REQ_CTRL) &&
                      (s_tdata[7:6] != itc_pkg::SEL_NONE) &&
                      (s_tdata[5:4] != itc_pkg::ACC_LATCH);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> m_tvalid)
        else $error("accepted request without result beat");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (s_tuser != itc_pkg::REQ_READ) |=> m_tdata[7:0] == 8'h00)
        else $error("non-read request returned nonzero data");

    a_mode0_low: assert property (@(posedge clk) disable iff (!rst_n)
        mode_set && (s_tdata[3:1] == itc_pkg::MODE_INT_TERM) |=> !m_tdata[8])
        else $error("mode 0 setup did not drive OUT low");

    a_modex_high: assert property (@(posedge clk) disable iff (!rst_n)
        mode_set && (s_tdata[3:1] != itc_pkg::MODE_INT_TERM) |=> m_tdata[8])
        else $error("mode setup did not drive OUT high");

endmodule

bind interval_timer_counter_channel_unit itc_assertions u_itc_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/itc_checker.sv
// Checker for the interval timer channel: predicts each result beat and compares it.
`timescale 1ns / 1ps

module itc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data, [8] level, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] read_data, [8] out_pin, [15:9] zero
    output int          errors,
    output int          pending,
    output int          req_beats,
    output int          res_beats
);

    typedef struct packed {
        logic [7:0] rd_byte;
        logic       out_pin;
    } timer_beat_t;

    timer_beat_t timer_results[$];
    int          err_cnt;
    int          req_cnt;
    int          res_cnt;

    // Channel state
    logic [2:0]  mode_r;
    logic [1:0]  acc_r;
    logic [15:0] reload_r;
    logic [15:0] count_r;
    logic [15:0] latch_r;
    logic        latch_full;
    logic        rd_hi;
    logic        wr_hi;
    logic        load_pend;
    logic        wait_cnt;
    logic        gate_lvl;
    logic        gate_trig;
    logic        gate_smp;
    logic        out_r;
    logic        clk_pin;
    logic        odd_r;
    logic        strobe_done;

    function automatic void clear_timer();
        mode_r      = '0;
        acc_r       = '0;
        reload_r    = '0;
        count_r     = '0;
        latch_r     = '0;
        latch_full  = 1'b0;
        rd_hi       = 1'b0;
        wr_hi       = 1'b0;
        load_pend   = 1'b0;
        wait_cnt    = 1'b0;
        gate_lvl    = 1'b0;
        gate_trig   = 1'b0;
        gate_smp    = 1'b0;
        out_r       = 1'b0;
        clk_pin     = 1'b0;
        odd_r       = 1'b0;
        strobe_done = 1'b0;
    endfunction

    // Fold modes 6 and 7 onto 2 and 3
    function automatic logic [2:0] live_mode();
        return (mode_r[2:1] == 2'b11) ? {1'b0, mode_r[1:0]} : mode_r;
    endfunction

    function automatic void restart_mode();
        logic [2:0] m;
        m         = live_mode();
        wait_cnt  = 1'b1;
        load_pend = 1'b0;
        if (m == itc_pkg::MODE_INT_TERM) begin
            out_r = 1'b0;
        end
        else begin
            out_r     = 1'b1;
            gate_smp  = 1'b0;
            gate_trig = 1'b0;
            if (m == itc_pkg::MODE_SQUARE)
                odd_r = 1'b0;
        end
    endfunction

    function automatic void ctrl_write(logic [7:0] d);
        if (d[7:6] == itc_pkg::SEL_NONE)
            return;
        if (d[5:4] == itc_pkg::ACC_LATCH) begin
            // a second latch is dropped while the first is unread
            if (!latch_full) begin
                latch_r    = count_r;
                latch_full = 1'b1;
                rd_hi      = 1'b0;
            end
        end
        else begin
            acc_r  = d[5:4];
            mode_r = d[3:1];
            rd_hi  = 1'b0;
            wr_hi  = 1'b0;
            restart_mode();
        end
    endfunction

    function automatic void count_write(logic [7:0] d);
        logic       done;
        logic [2:0] m;
        done = 1'b0;
        m    = live_mode();
        case (acc_r)
            itc_pkg::ACC_LOW: begin
                reload_r = {8'h00, d};
                done     = 1'b1;
            end
            itc_pkg::ACC_HIGH: begin
                reload_r = {d, 8'h00};
                done     = 1'b1;
            end
            itc_pkg::ACC_BOTH: begin
                if (!wr_hi) begin
                    reload_r = (reload_r & itc_pkg::MASK_HIGH) | {8'h00, d};
                    wait_cnt = 1'b1;
                    if (m == itc_pkg::MODE_INT_TERM)
                        out_r = 1'b0;
                end
                else begin
                    reload_r = (reload_r & itc_pkg::MASK_LOW) | {d, 8'h00};
                    done     = 1'b1;
                end
                wr_hi = !wr_hi;
            end
            default: ;
        endcase
        if (!done)
            return;
        if (m == itc_pkg::MODE_INT_TERM || m == itc_pkg::MODE_SW_STROBE)
            load_pend = 1'b1;
        else if (m == itc_pkg::MODE_RATE_GEN || m == itc_pkg::MODE_SQUARE)
            load_pend = wait_cnt;
        wait_cnt = 1'b0;
    endfunction

    function automatic logic [7:0] byte_read();
        logic [15:0] src;
        logic [7:0]  r;
        src = latch_full ? latch_r : count_r;
        case (acc_r)
            itc_pkg::ACC_LOW: begin
                latch_full = 1'b0;
                return src[7:0];
            end
            itc_pkg::ACC_HIGH: begin
                latch_full = 1'b0;
                return src[15:8];
            end
            itc_pkg::ACC_BOTH: begin
                if (!rd_hi) begin
                    r = src[7:0];
                end
                else begin
                    r          = src[15:8];
                    latch_full = 1'b0;
                end
                rd_hi = !rd_hi;
                return r;
            end
            default: return 8'h00;
        endcase
    endfunction

    function automatic void gate_change(logic v);
        logic [2:0] m;
        m = live_mode();
        if (gate_lvl == v)
            return;
        gate_lvl = v;
        if (v) begin
            if (m == itc_pkg::MODE_ONE_SHOT || m == itc_pkg::MODE_HW_STROBE) begin
                gate_trig = 1'b1;
            end
            else if (m == itc_pkg::MODE_RATE_GEN || m == itc_pkg::MODE_SQUARE) begin
                gate_smp  = 1'b1;
                gate_trig = 1'b1;
                load_pend = 1'b1;
            end
        end
        else if (m == itc_pkg::MODE_RATE_GEN || m == itc_pkg::MODE_SQUARE) begin
            out_r = 1'b1;
        end
    endfunction

    function automatic void reload_square();
        count_r = reload_r & itc_pkg::MASK_EVEN;
        odd_r   = reload_r[0];
    endfunction

    // One-clock low strobe when the count reaches zero
    function automatic void strobe_step();
        count_r = count_r - 16'd1;
        if (count_r == 16'd0 && !strobe_done) begin
            out_r       = 1'b0;
            strobe_done = 1'b1;
        end
        else begin
            out_r = 1'b1;
        end
    endfunction

    function automatic void clock_fall();
        case (live_mode())
            itc_pkg::MODE_INT_TERM: begin
                if (load_pend) begin
                    count_r   = reload_r;
                    load_pend = 1'b0;
                end
                else if (gate_smp) begin
                    count_r = count_r - 16'd1;
                    if (count_r == 16'd0)
                        out_r = 1'b1;
                end
            end
            itc_pkg::MODE_ONE_SHOT: begin
                if (gate_smp)
                    load_pend = 1'b1;
                if (load_pend) begin
                    count_r   = reload_r;
                    out_r     = 1'b0;
                    load_pend = 1'b0;
                end
                else begin
                    count_r = count_r - 16'd1;
                    if (count_r == 16'd0)
                        out_r = 1'b1;
                end
            end
            itc_pkg::MODE_RATE_GEN: begin
                if (gate_smp && load_pend) begin
                    count_r   = reload_r;
                    out_r     = 1'b1;
                    load_pend = 1'b0;
                end
                else if (!gate_smp) begin
                    out_r = 1'b1;
                end
                else begin
                    count_r = count_r - 16'd1;
                    if (count_r == 16'd0)
                        count_r = reload_r;
                    out_r = (count_r != 16'd1);
                end
            end
            itc_pkg::MODE_SQUARE: begin
                if (gate_smp && load_pend) begin
                    reload_square();
                    out_r     = 1'b1;
                    load_pend = 1'b0;
                end
                else if (!gate_smp) begin
                    out_r = 1'b1;
                end
                else if (odd_r && out_r) begin
                    // odd reload: the high half lasts longer than the low half
                    if (count_r == 16'd0) begin
                        reload_square();
                        out_r = !out_r;
                    end
                    else begin
                        count_r = count_r - 16'd2;
                    end
                end
                else begin
                    count_r = count_r - 16'd2;
                    if (count_r == 16'd0) begin
                        reload_square();
                        out_r = !out_r;
                    end
                end
            end
            itc_pkg::MODE_SW_STROBE: begin
                if (load_pend) begin
                    count_r     = reload_r;
                    load_pend   = 1'b0;
                    strobe_done = 1'b0;
                end
                else if (gate_smp) begin
                    strobe_step();
                end
            end
            default: begin
                if (gate_smp)
                    load_pend = 1'b1;
                if (load_pend) begin
                    count_r     = reload_r;
                    load_pend   = 1'b0;
                    strobe_done = 1'b0;
                end
                else begin
                    strobe_step();
                end
            end
        endcase
    endfunction

    function automatic void clock_change(logic v);
        logic [2:0] m;
        if (clk_pin == v)
            return;
        clk_pin = v;
        if (wait_cnt)
            return;
        if (!v) begin
            clock_fall();
            return;
        end
        // rising CLK samples GATE
        m = live_mode();
        if (m == itc_pkg::MODE_INT_TERM || m == itc_pkg::MODE_SW_STROBE)
            gate_smp = gate_lvl;
        else if (m == itc_pkg::MODE_ONE_SHOT || m == itc_pkg::MODE_HW_STROBE)
            gate_smp = gate_trig;
        else
            gate_smp = gate_trig || gate_lvl;
        gate_trig = 1'b0;
    endfunction

    function automatic timer_beat_t predict_timer(logic [2:0] req, logic [7:0] d, logic lv);
        timer_beat_t b;
        b.rd_byte = 8'h00;
        case (req)
            itc_pkg::REQ_CTRL:  ctrl_write(d);
            itc_pkg::REQ_WRITE: count_write(d);
            itc_pkg::REQ_READ:  b.rd_byte = byte_read();
            itc_pkg::REQ_GATE:  gate_change(lv);
            itc_pkg::REQ_CLOCK: clock_change(lv);
            default: ;
        endcase
        b.out_pin = out_r;
        return b;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        timer_beat_t want;
        if (!rst_n) begin
            clear_timer();
            timer_results.delete();
            err_cnt   = 0;
            req_cnt   = 0;
            res_cnt   = 0;
            errors    <= 0;
            pending   <= 0;
            req_beats <= 0;
            res_beats <= 0;
        end
        else begin
            // compare first: a result taken on this edge belongs to an older request
            if (m_tvalid && m_tready) begin
                res_cnt++;
                if (timer_results.size() == 0) begin
                    $error("result beat with no request outstanding: read_data %0d out_pin %0d",
                           m_tdata[7:0], m_tdata[8]);
                    err_cnt++;
                end
                else begin
                    want = timer_results.pop_front();
                    if (m_tdata[7:0] !== want.rd_byte) begin
                        $error("read_data mismatch: expected %0d, got %0d",
                               want.rd_byte, m_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_tdata[8] !== want.out_pin) begin
                        $error("out_pin mismatch: expected %0d, got %0d",
                               want.out_pin, m_tdata[8]);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                req_cnt++;
                timer_results.push_back(predict_timer(s_tuser, s_tdata[7:0], s_tdata[8]));
            end
            errors    <= err_cnt;
            pending   <= timer_results.size();
            req_beats <= req_cnt;
            res_beats <= res_cnt;
        end
    end

endmodule

### dv/tb.sv
// Testbench top for the interval timer channel: stimulus, idle profiles and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int BEATS_PER_PHASE = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 4;

    // Request codes outside the defined set
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // Raw mode codes that alias rate generator and square wave
    localparam logic [2:0] MODE_RATE_ALT   = 3'd6;
    localparam logic [2:0] MODE_SQUARE_ALT = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] data, [8] level, [15:9] zero
    logic [2:0]  s_tuser  = itc_pkg::REQ_CTRL;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // [7:0] read_data, [8] out_pin, [15:9] zero

    int errors;
    int pending;
    int req_beats;
    int res_beats;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int sent       = 0;
    int quiet_cyc  = 0;

    // Pin levels as last sent, so toggles can be generated
    logic clk_lvl  = 1'b0;
    logic gate_lvl = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    interval_timer_counter_channel_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    itc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .req_beats (req_beats),
        .res_beats (res_beats)
    );

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: end the run when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cyc <= 0;
        end
        else if (quiet_cyc >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    function automatic logic [7:0] ctrl_word(logic [1:0] sel, logic [1:0] acc,
                                             logic [2:0] mode, logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    // Offer one request beat, with idle gaps ahead of it, and hold it until taken
    task automatic send_beat(logic [2:0] req, logic [7:0] d, logic lv);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, lv, d};
        if (req == itc_pkg::REQ_GATE)
            gate_lvl = lv;
        if (req == itc_pkg::REQ_CLOCK)
            clk_lvl = lv;
        sent++;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic load_count(logic [1:0] acc, logic [15:0] value);
        case (acc)
            itc_pkg::ACC_LOW:
                send_beat(itc_pkg::REQ_WRITE, value[7:0], 1'($urandom_range(0, 1)));
            itc_pkg::ACC_HIGH:
                send_beat(itc_pkg::REQ_WRITE, value[15:8], 1'($urandom_range(0, 1)));
            default: begin
                send_beat(itc_pkg::REQ_WRITE, value[7:0], 1'($urandom_range(0, 1)));
                send_beat(itc_pkg::REQ_WRITE, value[15:8], 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // Program a mode, load a count, then run the pins with reads and noise mixed in
    task automatic run_program();
        logic [2:0]  mode;
        logic [1:0]  acc;
        logic [15:0] value;
        int          steps;
        int          pick;
        mode  = 3'($urandom_range(0, 7));
        acc   = 2'($urandom_range(itc_pkg::ACC_LOW, itc_pkg::ACC_BOTH));
        // mostly short counts so terminal count is reached; now and then a wide one
        value = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        if (acc == itc_pkg::ACC_HIGH && $urandom_range(0, 3) != 0)
            value = {value[7:0], 8'h00};
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(2'($urandom_range(0, itc_pkg::SEL_NONE - 1)), acc, mode,
                            1'($urandom_range(0, 1))),
                  1'($urandom_range(0, 1)));
        load_count(acc, value);
        if ($urandom_range(0, 1))
            send_beat(itc_pkg::REQ_GATE, 8'($urandom), 1'b1);
        steps = $urandom_range(20, 60);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                send_beat(itc_pkg::REQ_CLOCK, 8'($urandom),
                          ($urandom_range(0, 19) == 0) ? clk_lvl : !clk_lvl);
            else if (pick < 70)
                send_beat(itc_pkg::REQ_GATE, 8'($urandom), !gate_lvl);
            else if (pick < 80)
                send_beat(itc_pkg::REQ_READ, 8'($urandom), 1'($urandom_range(0, 1)));
            else if (pick < 86)
                send_beat(itc_pkg::REQ_CTRL,
                          ctrl_word(2'($urandom_range(0, itc_pkg::SEL_NONE - 1)),
                                    itc_pkg::ACC_LATCH, 3'($urandom),
                                    1'($urandom_range(0, 1))),
                          1'($urandom_range(0, 1)));
            else if (pick < 92)
                send_beat(itc_pkg::REQ_WRITE, 8'($urandom_range(0, 30)),
                          1'($urandom_range(0, 1)));
            else
                send_beat(3'($urandom_range(0, REQ_SPARE_HI)), 8'($urandom),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int phase_end;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: access mode left from reset ignores writes and reads zero
        send_beat(itc_pkg::REQ_WRITE, 8'hff, 1'b1);
        send_beat(itc_pkg::REQ_READ, 8'h00, 1'b0);
        // Undefined request codes
        send_beat(REQ_SPARE_LO, 8'hff, 1'b1);
        send_beat(REQ_SPARE_HI, 8'h00, 1'b0);
        // Select field of all ones leaves the word without effect
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(itc_pkg::SEL_NONE, itc_pkg::ACC_BOTH, itc_pkg::MODE_RATE_GEN, 1'b1),
                  1'b0);
        // Interrupt on terminal count, full-width count, BCD bit set but ignored
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(2'd0, itc_pkg::ACC_BOTH, itc_pkg::MODE_INT_TERM, 1'b1), 1'b0);
        send_beat(itc_pkg::REQ_WRITE, 8'hff, 1'b0);
        send_beat(itc_pkg::REQ_WRITE, 8'hff, 1'b0);
        send_beat(itc_pkg::REQ_GATE, 8'h00, 1'b1);
        send_beat(itc_pkg::REQ_GATE, 8'h00, 1'b1);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b1);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b1);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b0);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b1);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b0);
        // Latch, then a second latch that must be dropped, then read both bytes
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(2'd0, itc_pkg::ACC_LATCH, itc_pkg::MODE_INT_TERM, 1'b0), 1'b0);
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(2'd0, itc_pkg::ACC_LATCH, itc_pkg::MODE_INT_TERM, 1'b0), 1'b0);
        send_beat(itc_pkg::REQ_READ, 8'h00, 1'b0);
        send_beat(itc_pkg::REQ_READ, 8'h00, 1'b0);
        // Aliased modes, the first loaded with a zero count
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(2'd2, itc_pkg::ACC_LOW, MODE_SQUARE_ALT, 1'b0), 1'b0);
        send_beat(itc_pkg::REQ_WRITE, 8'h00, 1'b0);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b1);
        send_beat(itc_pkg::REQ_CLOCK, 8'h00, 1'b0);
        send_beat(itc_pkg::REQ_CTRL,
                  ctrl_word(2'd1, itc_pkg::ACC_HIGH, MODE_RATE_ALT, 1'b1), 1'b1);
        send_beat(itc_pkg::REQ_WRITE, 8'h80, 1'b1);
        send_beat(itc_pkg::REQ_READ, 8'hff, 1'b1);
        drain();

        // Four idle profiles: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 78 : (phase == 3) ? 33 : 0;
            stall_pct <= (phase == 2) ? 78 : (phase == 3) ? 33 : 0;
            phase_end = sent + BEATS_PER_PHASE;
            while (sent < phase_end)
                run_program();
            drain();
        end

        // Let the last result settle, then give the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d request beats and %0d result beats: all eight counter modes,",
                 req_beats, res_beats);
        $display("three byte access modes, count latching, pin noise and four idle profiles.");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
